// ----- hdl/abkf_pkg.sv -----
// Shared types, constants and saturation helpers for the angle/bias Kalman filter.
package abkf_pkg;

   localparam int COV_FRAC_BITS = 32;
   localparam int NOISE_UP      = COV_FRAC_BITS - 24;

   localparam logic [7:0] REG_TIME_STEP   = 8'd0;
   localparam logic [7:0] REG_ANGLE_NOISE = 8'd1;
   localparam logic [7:0] REG_BIAS_NOISE  = 8'd2;
   localparam logic [7:0] REG_MEAS_NOISE  = 8'd3;

   localparam logic [23:0] RST_TIME_STEP   = 24'd167772;
   localparam logic [23:0] RST_ANGLE_NOISE = 24'd16777;
   localparam logic [23:0] RST_BIAS_NOISE  = 24'd50332;
   localparam logic [23:0] RST_MEAS_NOISE  = 24'd503316;

   typedef struct packed {
      logic signed [31:0] measured_angle;
      logic signed [31:0] measured_rate;
   } req_type;

   typedef struct packed {
      logic signed [31:0] filtered_angle;
      logic signed [31:0] bias_estimate;
   } rsp_type;

   // divider handshake between sequencer and divider
   typedef struct packed {
      logic               start;
      logic signed [47:0] num;
      logic        [48:0] den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] quot;
   } div_rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (x < -64'sh0000_0000_8000_0000) r = 32'sh8000_0000;
      else r = x[31:0];
      return r;
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [63:0] x);
      logic signed [47:0] r;
      if (x > 64'sh0000_7FFF_FFFF_FFFF) r = 48'sh7FFF_FFFF_FFFF;
      else if (x < -64'sh0000_8000_0000_0000) r = 48'sh8000_0000_0000;
      else r = x[47:0];
      return r;
   endfunction

endpackage

// ----- hdl/abkf_div.sv -----
// Restoring divider for the Q1.30 gains: one compare-subtract per cycle.
module abkf_div
   import abkf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   typedef enum logic [3:0] {
      D_IDLE  = 4'b0001,
      D_CHECK = 4'b0010,
      D_ITER  = 4'b0100,
      D_DONE  = 4'b1000
   } dstate_type;

   dstate_type state_ff, state_in;
   logic [47:0] ua_ff, ua_in;
   logic [48:0] ub_ff, ub_in;
   logic [49:0] rem_ff, rem_in;
   logic [30:0] q_ff, q_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in;
   logic [49:0] rem2;

   assign rem2 = {rem_ff[48:0], 1'b0};

   always_comb begin
      state_in = state_ff;
      ua_in    = ua_ff;
      ub_in    = ub_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      case (state_ff)
         D_IDLE: begin
            if (div_req.start) begin
               neg_in   = div_req.num[47];
               ua_in    = div_req.num[47] ? 48'(-div_req.num) : 48'(div_req.num);
               ub_in    = div_req.den;
               state_in = D_CHECK;
            end
         end
         D_CHECK: begin
            cnt_in = 5'd0;
            if ({2'b00, ua_ff} >= {ub_ff, 1'b0}) begin
               q_in     = 31'h7FFF_FFFF;
               state_in = D_DONE;
            end else if ({1'b0, ua_ff} >= ub_ff) begin
               q_in     = 31'd1;
               rem_in   = {2'b00, ua_ff} - {1'b0, ub_ff};
               state_in = D_ITER;
            end else begin
               q_in     = 31'd0;
               rem_in   = {2'b00, ua_ff};
               state_in = D_ITER;
            end
         end
         D_ITER: begin
            if (rem2 >= {1'b0, ub_ff}) begin
               rem_in = rem2 - {1'b0, ub_ff};
               q_in   = {q_ff[29:0], 1'b1};
            end else begin
               rem_in = rem2;
               q_in   = {q_ff[29:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd29) state_in = D_DONE;
         end
         D_DONE: begin
            state_in = D_IDLE;
         end
         default: state_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ua_ff  <= ua_in;
      ub_ff  <= ub_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   assign div_rsp.done = (state_ff == D_DONE);
   assign div_rsp.quot = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});

endmodule

// ----- hdl/angle_bias_kalman_filter.sv -----
// Top level: two-state angle/gyro-bias Kalman filter with a shared multiplier.
// Each transaction runs ten multiply-and-round steps on one 26x33 multiplier. Each step goes
// through low half, then high half of the wide operand, then accumulate, then write back.
// There are also two gain divisions in the divider. Each division runs a start, a range
// check, 30 quotient bits and a done state. A saturated gain skips the quotient bits and goes
// straight from the range check to done. Both divisions are skipped when the innovation
// variance is not positive, and the gains are then zero. req_stall is high while
// an item is in flight. The result sits in an output register, so the next item can be taken
// while it waits. A finished item holds in its last state while an earlier result is stalled.
module angle_bias_kalman_filter
   import abkf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write_en,
   input  logic [7:0]  csr_index,
   input  logic [23:0] csr_write_data
);

   typedef enum logic [9:0] {
      S_IDLE    = 10'b00_0000_0001,
      S_MUL_LO  = 10'b00_0000_0010,
      S_MUL_HI  = 10'b00_0000_0100,
      S_MUL_ACC = 10'b00_0000_1000,
      S_MUL_WB  = 10'b00_0001_0000,
      S_DIV0_GO = 10'b00_0010_0000,
      S_DIV0_WT = 10'b00_0100_0000,
      S_DIV1_GO = 10'b00_1000_0000,
      S_DIV1_WT = 10'b01_0000_0000,
      S_DONE    = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [23:0] dt_ff, qa_reg_ff, qb_reg_ff, r_reg_ff;

   logic signed [31:0] angle_ff, angle_in;
   logic signed [31:0] bias_ff, bias_in;
   logic signed [47:0] cov_ff [4];
   logic signed [47:0] cov_in [4];

   logic signed [31:0] meas_ff, meas_in;
   logic signed [32:0] rate_ff, rate_in;
   logic signed [32:0] y_ff, y_in;
   logic signed [48:0] dp11_ff, dp11_in;
   logic signed [49:0] t_ff, t_in;
   logic signed [31:0] k0_ff, k0_in, k1_ff, k1_in;
   logic [3:0]         op_ff, op_in;

   logic signed [58:0] prod_ff, prod_in;
   logic signed [83:0] acc_ff, acc_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic signed [47:0] qa, qb, r_cov;
   logic signed [49:0] a_op;
   logic signed [32:0] b_op;
   logic signed [25:0] mul_a;
   logic signed [83:0] rnd24, rnd30;
   logic signed [63:0] rnd;
   logic signed [48:0] s_var;

   div_req_type div_req;
   div_rsp_type div_rsp;

   abkf_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign qa    = 48'(signed'({24'd0, qa_reg_ff}) <<< NOISE_UP);
   assign qb    = 48'(signed'({24'd0, qb_reg_ff}) <<< NOISE_UP);
   assign r_cov = 48'(signed'({24'd0, r_reg_ff}) <<< NOISE_UP);
   assign s_var = 49'(cov_ff[0]) + 49'(r_cov);

   // operand selection per step
   always_comb begin
      a_op = '0;
      b_op = $signed({9'd0, dt_ff});
      case (op_ff)
         4'd0: a_op = 50'(rate_ff);
         4'd1: a_op = 50'(cov_ff[3]);
         4'd2: a_op = 50'(qb);
         4'd3: a_op = t_ff;
         4'd4: begin a_op = 50'(y_ff);      b_op = 33'(k0_ff); end
         4'd5: begin a_op = 50'(y_ff);      b_op = 33'(k1_ff); end
         4'd6: begin a_op = 50'(cov_ff[0]); b_op = 33'(k1_ff); end
         4'd7: begin a_op = 50'(cov_ff[1]); b_op = 33'(k1_ff); end
         4'd8: begin a_op = 50'(cov_ff[0]); b_op = 33'(k0_ff); end
         4'd9: begin a_op = 50'(cov_ff[1]); b_op = 33'(k0_ff); end
         default: a_op = '0;
      endcase
   end

   // low slice is unsigned, high slice carries the sign
   assign mul_a   = (state_ff == S_MUL_LO) ? $signed({1'b0, a_op[24:0]})
                                           : $signed({a_op[49], a_op[49:25]});
   assign prod_in = 59'(mul_a) * 59'(b_op);

   assign rnd24 = (acc_ff + (84'sd1 <<< 23)) >>> 24;
   assign rnd30 = (acc_ff + (84'sd1 <<< 29)) >>> 30;
   assign rnd   = (op_ff >= 4'd4) ? rnd30[63:0] : rnd24[63:0];

   always_comb begin
      state_in     = state_ff;
      angle_in     = angle_ff;
      bias_in      = bias_ff;
      cov_in       = cov_ff;
      meas_in      = meas_ff;
      rate_in      = rate_ff;
      y_in         = y_ff;
      dp11_in      = dp11_ff;
      t_in         = t_ff;
      k0_in        = k0_ff;
      k1_in        = k1_ff;
      op_in        = op_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      div_req.start = 1'b0;
      div_req.num   = cov_ff[0];
      div_req.den   = s_var[48:0];
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               meas_in  = req_data.measured_angle;
               rate_in  = 33'(req_data.measured_rate) - 33'(bias_ff);
               op_in    = 4'd0;
               state_in = S_MUL_LO;
            end
         end
         S_MUL_LO: state_in = S_MUL_HI;
         S_MUL_HI: begin
            acc_in   = 84'(prod_ff);
            state_in = S_MUL_ACC;
         end
         S_MUL_ACC: begin
            acc_in   = acc_ff + (84'(prod_ff) <<< 25);
            state_in = S_MUL_WB;
         end
         S_MUL_WB: begin
            op_in    = op_ff + 4'd1;
            state_in = S_MUL_LO;
            case (op_ff)
               4'd0: angle_in = sat32(64'(angle_ff) + rnd);
               4'd1: dp11_in  = rnd[48:0];
               4'd2: begin
                  cov_in[3] = sat48(64'(cov_ff[3]) + rnd);
                  t_in = 50'(dp11_ff) - 50'(cov_ff[1]) - 50'(cov_ff[2]) + 50'(qa);
               end
               4'd3: begin
                  cov_in[0] = sat48(64'(cov_ff[0]) + rnd);
                  cov_in[1] = sat48(64'(cov_ff[1]) - 64'(dp11_ff));
                  cov_in[2] = sat48(64'(cov_ff[2]) - 64'(dp11_ff));
                  y_in      = 33'(meas_ff) - 33'(angle_ff);
                  state_in  = S_DIV0_GO;
               end
               4'd4: angle_in  = sat32(64'(angle_ff) + rnd);
               4'd5: bias_in   = sat32(64'(bias_ff) + rnd);
               4'd6: cov_in[2] = sat48(64'(cov_ff[2]) - rnd);
               4'd7: cov_in[3] = sat48(64'(cov_ff[3]) - rnd);
               4'd8: cov_in[0] = sat48(64'(cov_ff[0]) - rnd);
               4'd9: begin
                  cov_in[1] = sat48(64'(cov_ff[1]) - rnd);
                  state_in  = S_DONE;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_DIV0_GO: begin
            if (s_var > 49'sd0) begin
               div_req.start = 1'b1;
               state_in      = S_DIV0_WT;
            end else begin
               // no usable innovation variance: zero gain
               k0_in    = '0;
               k1_in    = '0;
               state_in = S_MUL_LO;
            end
         end
         S_DIV0_WT: begin
            if (div_rsp.done) begin
               k0_in    = div_rsp.quot;
               state_in = S_DIV1_GO;
            end
         end
         S_DIV1_GO: begin
            div_req.start = 1'b1;
            div_req.num   = cov_ff[2];
            state_in      = S_DIV1_WT;
         end
         S_DIV1_WT: begin
            if (div_rsp.done) begin
               k1_in    = div_rsp.quot;
               state_in = S_MUL_LO;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.filtered_angle = angle_ff;
               rsp_data_in.bias_estimate  = bias_ff;
               state_in                   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         angle_ff     <= '0;
         bias_ff      <= '0;
         cov_ff       <= '{default: '0};
         dt_ff        <= RST_TIME_STEP;
         qa_reg_ff    <= RST_ANGLE_NOISE;
         qb_reg_ff    <= RST_BIAS_NOISE;
         r_reg_ff     <= RST_MEAS_NOISE;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         angle_ff     <= angle_in;
         bias_ff      <= bias_in;
         cov_ff       <= cov_in;
         if (csr_write_en) begin
            case (csr_index)
               REG_TIME_STEP:   dt_ff     <= csr_write_data;
               REG_ANGLE_NOISE: qa_reg_ff <= csr_write_data;
               REG_BIAS_NOISE:  qb_reg_ff <= csr_write_data;
               REG_MEAS_NOISE:  r_reg_ff  <= csr_write_data;
               default: ;
            endcase
         end
      end
      meas_ff     <= meas_in;
      rate_ff     <= rate_in;
      y_ff        <= y_in;
      dp11_ff     <= dp11_in;
      t_ff        <= t_in;
      k0_ff       <= k0_in;
      k1_ff       <= k1_in;
      op_ff       <= op_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the angle/bias Kalman filter: directed and random traffic against a predictor.
module tb_top;
   import abkf_pkg::*;

   class kalman_scoreboard;
      longint      angle_est;
      longint      bias_est;
      longint      cov [4];
      logic [23:0] step_reg;
      logic [23:0] qa_reg;
      logic [23:0] qb_reg;
      logic [23:0] meas_noise_reg;
      rsp_type     awaited [$];
      int          errors;

      function new();
         angle_est      = 0;
         bias_est       = 0;
         foreach (cov[i]) cov[i] = 0;
         step_reg       = RST_TIME_STEP;
         qa_reg         = RST_ANGLE_NOISE;
         qb_reg         = RST_BIAS_NOISE;
         meas_noise_reg = RST_MEAS_NOISE;
         errors         = 0;
      endfunction

      function void write_reg(logic [7:0] idx, logic [23:0] v);
         case (idx)
            REG_TIME_STEP: begin
               step_reg = v;
            end
            REG_ANGLE_NOISE: begin
               qa_reg = v;
            end
            REG_BIAS_NOISE: begin
               qb_reg = v;
            end
            REG_MEAS_NOISE: begin
               meas_noise_reg = v;
            end
            default: begin
            end
         endcase
      endfunction

      // round(p*m / 2^s), ties upward
      function longint mul_round(longint p, longint m, int s);
         logic signed [127:0] a;
         logic signed [127:0] b;
         logic signed [127:0] x;
         a = p;
         b = m;
         x = a * b + (128'sd1 <<< (s - 1));
         x = x >>> s;
         return longint'(x);
      endfunction

      function longint clamp(longint x, int bits);
         longint top;
         top = (64'sd1 <<< (bits - 1)) - 1;
         if (x > top) return top;
         if (x < -top - 1) return -top - 1;
         return x;
      endfunction

      // a*2^30/b truncated toward zero, magnitude capped just under 2.0
      function longint gain_of(longint a, longint b);
         logic [127:0] ua;
         logic [127:0] q;
         ua = (a < 0) ? -a : a;
         q  = (ua << 30) / b;
         if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
         return (a < 0) ? -longint'(q) : longint'(q);
      endfunction

      function void note_request(req_type rq);
         longint  meas, rate, dt, qa, qb, r;
         longint  p00, p01, p10, p11, dp11, t, s, k0, k1, y;
         rsp_type e;
         meas = longint'(rq.measured_angle);
         rate = longint'(rq.measured_rate) - bias_est;
         dt   = longint'(step_reg);
         qa   = longint'(qa_reg) <<< NOISE_UP;
         qb   = longint'(qb_reg) <<< NOISE_UP;
         r    = longint'(meas_noise_reg) <<< NOISE_UP;
         p00  = cov[0];
         p01  = cov[1];
         p10  = cov[2];
         p11  = cov[3];
         k0   = 0;
         k1   = 0;

         angle_est = clamp(angle_est + mul_round(rate, dt, 24), 32);
         dp11 = mul_round(p11, dt, 24);
         t    = dp11 - p01 - p10 + qa;
         p00  = clamp(p00 + mul_round(t, dt, 24), 48);
         p01  = clamp(p01 - dp11, 48);
         p10  = clamp(p10 - dp11, 48);
         p11  = clamp(p11 + mul_round(qb, dt, 24), 48);

         // gains stay zero when the innovation variance is not positive
         s = p00 + r;
         if (s > 0) begin
            k0 = gain_of(p00, s);
            k1 = gain_of(p10, s);
         end

         y         = meas - angle_est;
         angle_est = clamp(angle_est + mul_round(y, k0, 30), 32);
         bias_est  = clamp(bias_est + mul_round(y, k1, 30), 32);

         cov[0] = clamp(p00 - mul_round(p00, k0, 30), 48);
         cov[1] = clamp(p01 - mul_round(p01, k0, 30), 48);
         cov[2] = clamp(p10 - mul_round(p00, k1, 30), 48);
         cov[3] = clamp(p11 - mul_round(p01, k1, 30), 48);

         e.filtered_angle = angle_est[31:0];
         e.bias_estimate  = bias_est[31:0];
         awaited.push_back(e);
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_response(rsp_type got);
         rsp_type e;
         if (awaited.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", got));
         end else begin
            e = awaited.pop_front();
            if (got.filtered_angle !== e.filtered_angle)
               report_mismatch($sformatf("filtered_angle %h, want %h",
                                         got.filtered_angle, e.filtered_angle));
            if (got.bias_estimate !== e.bias_estimate)
               report_mismatch($sformatf("bias_estimate %h, want %h",
                                         got.bias_estimate, e.bias_estimate));
         end
      endtask
   endclass

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   req_type     req_data       = '0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_en   = 1'b0;
   logic [7:0]  csr_index      = '0;
   logic [23:0] csr_write_data = '0;

   kalman_scoreboard sb = new();
   bit quiet = 1'b0;   // no idling on either side
   int stall_hold = 0;

   angle_bias_kalman_filter i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   always @(negedge clock) begin
      if (stall_hold > 0) begin
         stall_hold--;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
         rsp_stall  = 1'b1;
         stall_hold = pick_gap();
      end else begin
         rsp_stall = 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_data);
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_item(logic signed [31:0] ang, logic signed [31:0] rate);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid               = 1'b1;
      req_data.measured_angle = ang;
      req_data.measured_rate  = rate;
      do @(posedge clock); while (req_stall);
      sb.note_request(req_data);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (sb.awaited.size() != 0) @(negedge clock);
      repeat (150) @(negedge clock);
   endtask

   task automatic write_reg(logic [7:0] idx, logic [23:0] v);
      csr_write_en   = 1'b1;
      csr_index      = idx;
      csr_write_data = v;
      sb.write_reg(idx, v);
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic write_all(logic [23:0] dt, logic [23:0] qa, logic [23:0] qb,
                            logic [23:0] r);
      write_reg(REG_TIME_STEP, dt);
      write_reg(REG_ANGLE_NOISE, qa);
      write_reg(REG_BIAS_NOISE, qb);
      write_reg(REG_MEAS_NOISE, r);
   endtask

   // mostly plausible tilt and rate, now and then any 32-bit value
   task automatic send_random();
      logic signed [31:0] ang;
      logic signed [31:0] rate;
      if ($urandom_range(0, 9) < 8) begin
         ang  = $signed($urandom_range(0, 2 * 5898240)) - 5898240;
         rate = $signed($urandom_range(0, 2 * 16777216)) - 16777216;
      end else begin
         ang  = $urandom;
         rate = $urandom;
      end
      send_item(ang, rate);
   endtask

   localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S_MIN = 32'sh8000_0000;

   initial begin
      repeat (9) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // reset settings, field extremes
      quiet = 1'b1;
      send_item(0, 0);
      send_item(32'sd65536, 32'sd0);
      send_item(S_MAX, S_MAX);
      send_item(S_MIN, S_MIN);
      send_item(S_MAX, S_MIN);
      send_item(S_MIN, S_MAX);
      send_item(-1, 1);
      send_item(32'sh5555_5555, 32'shAAAA_AAAA);
      quiet = 1'b0;
      send_item(32'shAAAA_AAAA, 32'sh5555_5555);
      send_item(0, 0);
      drain();

      // no noise and no step, with the covariance carried over from the items before
      write_all(24'd0, 24'd0, 24'd0, 24'd0);
      send_item(S_MAX, S_MIN);
      send_item(32'sd1234567, 32'sd7654321);
      send_item(S_MIN, S_MAX);
      drain();

      // every register at full scale
      write_all(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
      send_item(S_MAX, S_MAX);
      send_item(S_MIN, S_MIN);
      send_item(S_MAX, S_MIN);
      send_item(0, S_MAX);
      send_item(S_MIN, 0);
      drain();

      // ignored out-of-range register writes, then a zero measurement noise
      write_reg(8'($urandom_range(REG_MEAS_NOISE + 1, 255)), 24'($urandom));
      write_reg(8'hFF, 24'hFF_FFFF);
      write_reg(REG_MEAS_NOISE, 24'd0);
      send_item(32'sd100000, -32'sd100000);
      send_item(S_MIN, S_MAX);
      drain();

      for (int ph = 0; ph < 11; ph++) begin
         quiet = (ph % 4 == 3);
         if (ph % 3 == 2)
            write_all(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
         else
            write_all(24'($urandom_range(16777, 1677721)), 24'($urandom_range(0, 1 << 20)),
                      24'($urandom_range(0, 1 << 20)), 24'($urandom_range(0, 1 << 22)));
         if ($urandom_range(0, 3) == 0)
            write_reg(8'($urandom_range(REG_MEAS_NOISE + 1, 255)), 24'($urandom));
         repeat (115) send_random();
         drain();
      end
      quiet = 1'b0;

      if (sb.awaited.size() != 0)
         sb.report_mismatch($sformatf("%0d results never arrived", sb.awaited.size()));
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ----- angle_bias_kalman_filter.f -----
hdl/abkf_pkg.sv
hdl/abkf_div.sv
hdl/angle_bias_kalman_filter.sv
bench/tb_top.sv
